/* rtl/core/rtic_pkg.sv */
// rtic_pkg: shared types and constants for the relay toggle interlock controller.
// No dependencies; compile first.
package rtic_pkg;

	localparam int unsigned CHANNELS_DEF   = 6;
	localparam int unsigned SENSE_W        = 6;
	localparam int unsigned TICK_W         = 8;
	localparam logic [TICK_W-1:0] DEBOUNCE_RESET = 8'd20;
	localparam logic [TICK_W-1:0] TIMER_MAX      = 8'hFF;

	// Toggle-mode phase of one channel
	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_ON    = 2'd1,
		PH_ARMED = 2'd2,
		PH_OFF   = 2'd3
	} phase_t;

	// Step to the following phase; off wraps to idle
	function automatic phase_t next_phase(input phase_t ph);
		phase_t res;
		case (ph)
			PH_IDLE:  res = PH_ON;
			PH_ON:    res = PH_ARMED;
			PH_ARMED: res = PH_OFF;
			PH_OFF:   res = PH_IDLE;
			default:  res = PH_IDLE;
		endcase
		return res;
	endfunction

endpackage

/* rtl/core/rtic_if.sv */
// rtic_if: valid/ready channel interfaces for sample items and result items.
// Depends on rtic_pkg for field widths.
interface rtic_sample_if;
	logic                           valid;
	logic                           ready;
	logic [rtic_pkg::SENSE_W-1:0]   sense_n;
	logic [rtic_pkg::SENSE_W-1:0]   mode_bits;
	logic                           interlock_switch_n;

	modport source (output valid, output sense_n, output mode_bits,
		output interlock_switch_n, input ready);
	modport sink (input valid, input sense_n, input mode_bits,
		input interlock_switch_n, output ready);
endinterface

interface rtic_result_if;
	logic                           valid;
	logic                           ready;
	logic [rtic_pkg::SENSE_W-1:0]   relay_drive;
	logic                           interlock_active;

	modport source (output valid, output relay_drive, output interlock_active,
		input ready);
	modport sink (input valid, input relay_drive, input interlock_active,
		output ready);
endinterface

/* rtl/core/relay_toggle_interlock_ctrl.sv */
// relay_toggle_interlock_ctrl: relay driver with per-channel follow/toggle modes,
// debounce timers and a two-channel interlock. Depends on rtic_pkg and rtic_if.
//
//  channel   dir   handshake      payload
//  -------   ---   ------------   ------------------------------------------
//  sample    in    valid/ready    sense_n[5:0], mode_bits[5:0], interlock_switch_n
//  result    out   valid/ready    relay_drive[5:0], interlock_active
//  cfg       in    cfg_we         cfg_wdata[7:0] = debounce_ticks
//
// One item per cycle sustained while the result side keeps taking results.
// An accepted item sits in the input stage; it advances into the result register,
// and updates channel state, as soon as the result register is empty or is being
// taken. A stalled result stalls only the input stage, which still frees up in
// the cycle the result leaves. Reset clears phases, timers, pending flags, the
// relay latch and sets debounce_ticks to 20.
module relay_toggle_interlock_ctrl #(
	parameter int unsigned CHANNELS = rtic_pkg::CHANNELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rtic_pkg::TICK_W-1:0]   cfg_wdata,
	rtic_sample_if.sink                   sample,
	rtic_result_if.source                 result
);

	localparam int unsigned SW = rtic_pkg::SENSE_W;
	localparam int unsigned TW = rtic_pkg::TICK_W;

	// Configuration
	logic [TW-1:0] debounce_q;

	// Input stage
	logic          valid_s1;
	logic [SW-1:0] sense_s1;
	logic [SW-1:0] mode_s1;
	logic          ilk_sw_s1;

	// Result register
	logic          valid_s2;
	logic [SW-1:0] drive_s2;
	logic          ilk_s2;

	// Channel state
	rtic_pkg::phase_t     phase_q   [CHANNELS];
	logic [TW-1:0]        timer_q   [CHANNELS];
	logic [CHANNELS-1:0]  pending_q;
	logic [CHANNELS-1:0]  drive_q;

	// Next state
	rtic_pkg::phase_t     phase_nxt [CHANNELS];
	logic [TW-1:0]        timer_nxt [CHANNELS];
	logic [CHANNELS-1:0]  pending_nxt;
	logic [CHANNELS-1:0]  drive_nxt;

	logic                 advance;
	logic                 ilk;
	logic [CHANNELS-1:0]  sense_ext;
	logic [CHANNELS-1:0]  mode_ext;
	logic [CHANNELS+SW-1:0] sense_wide;
	logic [CHANNELS+SW-1:0] mode_wide;
	logic [CHANNELS+SW-1:0] drive_wide;

	// Move the held item into the result register when that register frees up
	assign advance      = valid_s1 && (!valid_s2 || result.ready);
	assign sample.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= rtic_pkg::DEBOUNCE_RESET;
		end else if (cfg_we) begin
			debounce_q <= cfg_wdata;
		end
	end

	// Input stage: hold the item until it advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			sense_s1  <= sample.sense_n;
			mode_s1   <= sample.mode_bits;
			ilk_sw_s1 <= sample.interlock_switch_n;
		end
	end

	// Widen or trim the six-bit fields to the channel count; missing bits read 0
	assign sense_wide = {{CHANNELS{1'b0}}, sense_s1};
	assign mode_wide  = {{CHANNELS{1'b0}}, mode_s1};
	assign sense_ext  = sense_wide[CHANNELS-1:0];
	assign mode_ext   = mode_wide[CHANNELS-1:0];

	// Interlock applies when the switch and both coupled channels' mode bits are low
	assign ilk = !ilk_sw_s1 && !mode_ext[0] && !mode_ext[1];

	// Channel update, lowest channel first: channel 1 sees relay 0 already updated
	always_comb begin
		logic   pressed;
		logic   cond;
		logic   allowed;
		logic [TW-1:0] tmr;

		drive_nxt   = drive_q;
		pending_nxt = pending_q;
		for (int k = 0; k < CHANNELS; k++) begin
			phase_nxt[k] = phase_q[k];
			timer_nxt[k] = timer_q[k];
		end

		for (int k = 0; k < CHANNELS; k++) begin
			pressed = !sense_ext[k];
			allowed = 1'b1;
			cond    = 1'b0;
			tmr     = timer_q[k];

			if (mode_ext[k]) begin
				// Follow mode: relay tracks the press, phase holds
				drive_nxt[k]   = pressed;
				pending_nxt[k] = 1'b0;
				timer_nxt[k]   = '0;
			end else begin
				if (phase_q[k] == rtic_pkg::PH_IDLE || phase_q[k] == rtic_pkg::PH_ARMED) begin
					if (ilk && k == 0 && drive_q[1])
						allowed = 1'b0;
					if (ilk && k == 1 && drive_nxt[0])
						allowed = 1'b0;
					cond = pressed && allowed;
				end else begin
					cond = !pressed;
				end

				if (!cond) begin
					// Condition dropped: cancel any pending confirmation
					pending_nxt[k] = 1'b0;
					timer_nxt[k]   = '0;
				end else begin
					if (!pending_q[k])
						tmr = '0;
					else if (timer_q[k] != rtic_pkg::TIMER_MAX)
						tmr = timer_q[k] + TW'(1);
					pending_nxt[k] = 1'b1;
					timer_nxt[k]   = tmr;

					if (tmr >= debounce_q) begin
						// Confirmed: take the phase step
						pending_nxt[k] = 1'b0;
						timer_nxt[k]   = '0;
						if (phase_q[k] == rtic_pkg::PH_IDLE)
							drive_nxt[k] = 1'b1;
						else if (phase_q[k] == rtic_pkg::PH_ARMED)
							drive_nxt[k] = 1'b0;
						phase_nxt[k] = rtic_pkg::next_phase(phase_q[k]);
					end
				end
			end
		end
	end

	// Commit channel state once per advancing item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			drive_q   <= '0;
			for (int k = 0; k < CHANNELS; k++) begin
				phase_q[k] <= rtic_pkg::PH_IDLE;
				timer_q[k] <= '0;
			end
		end else if (advance) begin
			pending_q <= pending_nxt;
			drive_q   <= drive_nxt;
			for (int k = 0; k < CHANNELS; k++) begin
				phase_q[k] <= phase_nxt[k];
				timer_q[k] <= timer_nxt[k];
			end
		end
	end

	// Report only the low six relays
	assign drive_wide = {{SW{1'b0}}, drive_nxt};

	// Result register: load on advance, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			drive_s2 <= drive_wide[SW-1:0];
			ilk_s2   <= ilk;
		end
	end

	assign result.valid            = valid_s2;
	assign result.relay_drive      = drive_s2;
	assign result.interlock_active = ilk_s2;

endmodule
